### rtl/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg: shared types and constants for the date adder
// Microcode word layout, the control program, and the calendar constants.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam logic [13:0] MAX_YEAR    = 14'd9999;
  localparam logic [13:0] CYCLE_YEARS = 14'd400;
  localparam logic [13:0] LAST_MOD400 = 14'd399;
  localparam logic [17:0] CYCLE_DAYS  = 18'd146097;
  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [4:0]  DAY_LAST    = 5'd31;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_MOD,
    OP_CYC,
    OP_MON,
    OP_EMIT
  } op_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    op_t   op;
    step_t next;
  } uword_t;

  localparam step_t ST_LOAD = 3'd0;
  localparam step_t ST_MOD  = 3'd1;
  localparam step_t ST_CYC  = 3'd2;
  localparam step_t ST_MON  = 3'd3;
  localparam step_t ST_EMIT = 3'd4;

  // Control program: each step holds until its done condition, then jumps.
  function automatic uword_t ucode(step_t pc);
    uword_t w;
    unique case (pc)
      ST_LOAD: w = '{op: OP_LOAD, next: ST_MOD};
      ST_MOD:  w = '{op: OP_MOD,  next: ST_CYC};
      ST_CYC:  w = '{op: OP_CYC,  next: ST_MON};
      ST_MON:  w = '{op: OP_MON,  next: ST_EMIT};
      ST_EMIT: w = '{op: OP_EMIT, next: ST_LOAD};
      default: w = '{op: OP_LOAD, next: ST_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] n;
    case (m) inside
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/dad_month_len.sv
// ----------------------------------------------------------------------------
// dad_month_len: length of the current month
// Leap test from the year's low bits and its remainder modulo 400.
// ----------------------------------------------------------------------------
module dad_month_len
  import dad_pkg::*;
(
  input  logic [1:0] year_lo,
  input  logic [8:0] year_mod400,
  input  logic [3:0] month,
  output logic [4:0] days
);

  logic century;
  logic leap;

  assign century = (year_mod400 == 9'd100) || (year_mod400 == 9'd200) ||
                   (year_mod400 == 9'd300);
  assign leap    = (year_lo == 2'd0) && !century;
  assign days    = month_days(month, leap);

endmodule

### rtl/date_add_days.sv
// ----------------------------------------------------------------------------
// date_add_days: add a day count to a Gregorian date
// Steps: one load, modulo-400 steps on the year, skips of whole 400-year
// cycles, month steps at one month per cycle, and one emit.
// One word in flight; the next is taken once the result is registered.
// Synchronous active-high reset returns the sequencer to the load step.
// ----------------------------------------------------------------------------
module date_add_days
  import dad_pkg::*;
#(
  parameter int ADD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start_valid,
  output logic                 start_stall,
  input  logic [13:0]          start_year,
  input  logic [3:0]           start_month,
  input  logic [4:0]           start_day,
  input  logic [ADD_WIDTH-1:0] days_to_add,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [13:0]          result_year,
  output logic [3:0]           result_month,
  output logic [4:0]           result_day,
  output logic                 year_overflow
);

  localparam int DW = (ADD_WIDTH + 1 > 18) ? ADD_WIDTH + 1 : 18;

  step_t         pc;
  uword_t        uw;
  logic [13:0]   year;
  logic [3:0]    month;
  logic [DW-1:0] day;
  logic [13:0]   mod400;
  logic          ovf;

  logic [13:0]   year_norm;
  logic [3:0]    month_norm;
  logic [4:0]    day_norm;
  logic [4:0]    dim;
  logic [13:0]   year_cyc;
  logic [13:0]   year_inc;
  logic          mod_done;
  logic          cyc_done;
  logic          mon_done;
  logic          out_free;

  assign uw = ucode(pc);

  assign year_norm  = (start_year == 14'd0) ? 14'd1 : start_year;
  assign month_norm = (start_month == 4'd0) ? MONTH_JAN :
                      (start_month > MONTH_DEC) ? MONTH_DEC : start_month;
  assign day_norm   = (start_day == 5'd0) ? 5'd1 : start_day;

  dad_month_len u_mlen (
    .year_lo     (year[1:0]),
    .year_mod400 (mod400[8:0]),
    .month       (month),
    .days        (dim)
  );

  assign year_cyc = year + CYCLE_YEARS;
  assign year_inc = year + 14'd1;
  assign mod_done = (mod400 < CYCLE_YEARS);
  assign cyc_done = ovf || (day <= DW'(CYCLE_DAYS));
  assign mon_done = ovf || (day <= DW'(dim));
  assign out_free = !result_valid || !result_stall;

  assign start_stall = (uw.op != OP_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= ST_LOAD;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (uw.op != OP_EMIT)) begin
        result_valid <= 1'b0;
      end
      unique case (uw.op)
        OP_LOAD: begin
          if (start_valid) begin
            year   <= year_norm;
            month  <= month_norm;
            day    <= DW'(day_norm) + DW'(days_to_add);
            mod400 <= year_norm;
            ovf    <= (year_norm > MAX_YEAR);
            pc     <= uw.next;
          end
        end
        OP_MOD: begin
          if (mod_done) begin
            pc <= uw.next;
          end else begin
            mod400 <= mod400 - CYCLE_YEARS;
          end
        end
        OP_CYC: begin
          if (cyc_done) begin
            pc <= uw.next;
          end else begin
            day  <= day - DW'(CYCLE_DAYS);
            year <= year_cyc;
            ovf  <= (year_cyc > MAX_YEAR);
          end
        end
        OP_MON: begin
          if (mon_done) begin
            pc <= uw.next;
          end else begin
            day <= day - DW'(dim);
            if (month == MONTH_DEC) begin
              month  <= MONTH_JAN;
              year   <= year_inc;
              ovf    <= (year_inc > MAX_YEAR);
              mod400 <= (mod400 == LAST_MOD400) ? 14'd0 : mod400 + 14'd1;
            end else begin
              month <= month + 4'd1;
            end
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            result_valid  <= 1'b1;
            result_year   <= ovf ? MAX_YEAR  : year;
            result_month  <= ovf ? MONTH_DEC : month;
            result_day    <= ovf ? DAY_LAST  : day[4:0];
            year_overflow <= ovf;
            pc            <= uw.next;
          end
        end
        default: begin
          pc <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
